[design/cti_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cti_pkg
// Shared constants, codes and state types of the calibration table
// interpolator.
// ----------------------------------------------------------------------------
package cti_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam int unsigned DATA_WIDTH_DEF  = 24;

	localparam int unsigned TOL_WIDTH = 8;
	localparam int unsigned IDX_WIDTH = 2;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;

	localparam logic [IDX_WIDTH-1:0] CFG_TOLERANCE = 2'd0;
	localparam logic [IDX_WIDTH-1:0] CFG_MODE      = 2'd1;

	localparam logic [2:0] OC_EXACT  = 3'd0;
	localparam logic [2:0] OC_INTERP = 3'd1;
	localparam logic [2:0] OC_OVER   = 3'd2;
	localparam logic [2:0] OC_UNDER  = 3'd3;
	localparam logic [2:0] OC_PASS   = 3'd4;
	localparam logic [2:0] OC_STORED = 3'd5;
	localparam logic [2:0] OC_FULL   = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_SCAN,
		ST_CALC,
		ST_MULDIV,
		ST_SUM,
		ST_FIN
	} cti_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} cti_md_phase_t;

endpackage
`default_nettype wire

[design/cti_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cti_if
// Valid/ready channels of the calibration table interpolator: request items
// and result items.
// ----------------------------------------------------------------------------
interface cti_in_if #(parameter int unsigned DW = 24) ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           command;
	logic signed [DW-1:0] sample_or_key;
	logic signed [DW-1:0] entry_value;

	modport source (output valid, command, sample_or_key, entry_value, input ready);
	modport sink   (input valid, command, sample_or_key, entry_value, output ready);
endinterface

interface cti_out_if #(parameter int unsigned DW = 24, parameter int unsigned CW = 5) ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] result_value;
	logic [2:0]           outcome;
	logic [CW-1:0]        entries_held;

	modport source (output valid, result_value, outcome, entries_held, input ready);
	modport sink   (input valid, result_value, outcome, entries_held, output ready);
endinterface
`default_nettype wire

[design/cti_muldiv.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cti_muldiv
// Serial unsigned multiply then divide: trunc(a * b / d), one bit a cycle,
// quotient clamped to 2^(DW+1).
// ----------------------------------------------------------------------------
module cti_muldiv
	import cti_pkg::*;
#(
	parameter int unsigned DW = DATA_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW:0]   a_mag,
	input  wire logic [DW:0]   b_mag,
	input  wire logic [DW:0]   divisor,
	output logic               done,
	output logic [DW+1:0]      quot
);

	localparam int unsigned PW   = 2 * DW + 2;
	localparam int unsigned CNTW = $clog2(PW + 1);

	cti_md_phase_t   phase_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [PW-1:0]   prod_q;
	logic [PW-1:0]   ash_q;
	logic [DW:0]     b_q;
	logic [DW:0]     d_q;
	logic [DW:0]     rem_q;
	logic [DW+1:0]   rem_n;
	logic [DW+1:0]   rem_sub;
	logic            ge;
	logic [PW-1:0]   lim;

	assign rem_n   = {rem_q, prod_q[PW-1]};
	assign ge      = rem_n >= {1'b0, d_q};
	assign rem_sub = rem_n - {1'b0, d_q};
	assign lim     = PW'(1) << (DW + 1);
	assign quot    = (prod_q > lim) ? lim[DW+1:0] : prod_q[DW+1:0];
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				MD_IDLE: begin
					if (start) begin
						phase_q <= MD_MUL;
						cnt_q   <= CNTW'(DW + 1);
					end
				end
				MD_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						phase_q <= MD_DIV;
						cnt_q   <= CNTW'(PW);
					end
				end
				MD_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						phase_q <= MD_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= MD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			MD_IDLE: begin
				if (start) begin
					prod_q <= '0;
					ash_q  <= {{(PW-DW-1){1'b0}}, a_mag};
					b_q    <= b_mag;
					d_q    <= divisor;
					rem_q  <= '0;
				end
			end
			MD_MUL: begin
				if (b_q[0]) prod_q <= prod_q + ash_q;
				ash_q <= {ash_q[PW-2:0], 1'b0};
				b_q   <= {1'b0, b_q[DW:1]};
			end
			MD_DIV: begin
				rem_q  <= ge ? rem_sub[DW:0] : rem_n[DW:0];
				prod_q <= {prod_q[PW-2:0], ge};
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[design/calibration_table_interpolator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// calibration_table_interpolator_unit
// Sorted key/value calibration table with exact match, linear interpolation
// and extrapolation of Q16.8 samples.
// ----------------------------------------------------------------------------
// One item is handled at a time; the result register lets the next item in
// while a result waits. An insert runs a read-compare-write loop over the
// entries it compares, on the single table memory. A lookup scans all held
// entries through the memory read port, and when it interpolates or
// extrapolates adds the serial multiply and divide. Table contents are
// undefined after reset; only held entries are ever read.
module calibration_table_interpolator_unit
	import cti_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	cti_in_if.sink                    in_ch,
	cti_out_if.source                 out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [IDX_WIDTH-1:0] cfg_index,
	input  wire logic [TOL_WIDTH-1:0] cfg_data
);

	localparam int unsigned DW = DATA_WIDTH;
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned SW = DW + 4;

	cti_state_t state_q, state_d;

	logic [2*DW-1:0] mem_q [TABLE_DEPTH];
	logic [2*DW-1:0] rdata_q;
	logic            re, we;
	logic [AW-1:0]   ra, wa;
	logic [2*DW-1:0] wd;

	logic [CW-1:0]        count_q;
	logic [TOL_WIDTH-1:0] tol_q;
	logic                 mode_q;
	logic                 out_valid_q;
	logic                 val_s1;
	logic [AW-1:0]        idx_s1;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        pos_q;

	logic signed [DW-1:0] s_q, v_q;
	logic signed [DW-1:0] res_q;
	logic [2:0]           oc_q;
	logic                 hit_q, have_lo_q, have_hi_q;
	logic signed [DW-1:0] hv_q, lk_q, lv_q, pk_q, pv_q, uk_q, uv_q;
	logic signed [DW-1:0] e0k_q, e0v_q, e1k_q, e1v_q;
	logic signed [DW-1:0] v0_q;
	logic                 neg_q;

	logic                 accept, out_free;
	logic signed [DW-1:0] rk, rv;
	logic signed [DW:0]   diff, absd;
	logic                 in_tol;
	logic signed [DW-1:0] k0, v0, k1, v1;
	logic                 sel_ok;
	logic [2:0]           sel_oc;
	logic signed [DW:0]   span, da, db;
	logic [DW:0]          amag, bmag, span_u;
	logic                 go_md;
	logic                 md_start, md_done;
	logic [DW+1:0]        quot;
	logic signed [DW+2:0] qs;
	logic signed [SW-1:0] addend, sum_hit, sum_int;

	function automatic logic signed [DW-1:0] sat(input logic signed [SW-1:0] x);
		logic [SW-DW:0] top;
		top = x[SW-1:DW-1];
		if ((&top) || !(|top)) return x[DW-1:0];
		return x[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
	endfunction

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	assign rk     = rdata_q[2*DW-1:DW];
	assign rv     = rdata_q[DW-1:0];
	assign diff   = {rk[DW-1], rk} - {s_q[DW-1], s_q};
	assign absd   = diff[DW] ? -diff : diff;
	assign in_tol = $unsigned(absd) < {{(DW+1-TOL_WIDTH){1'b0}}, tol_q};

	always_comb begin
		sel_ok = 1'b1;
		sel_oc = OC_INTERP;
		k0 = lk_q; v0 = lv_q; k1 = uk_q; v1 = uv_q;
		if (have_lo_q && have_hi_q) begin
			sel_oc = OC_INTERP;
		end else if (have_lo_q) begin
			k0 = pk_q; v0 = pv_q; k1 = lk_q; v1 = lv_q;
			sel_oc = OC_OVER;
		end else if (have_hi_q && count_q >= CW'(2)) begin
			k0 = e0k_q; v0 = e0v_q; k1 = e1k_q; v1 = e1v_q;
			sel_oc = OC_UNDER;
		end else begin
			sel_ok = 1'b0;
		end
	end

	assign span  = {k1[DW-1], k1} - {k0[DW-1], k0};
	assign da    = {v1[DW-1], v1} - {v0[DW-1], v0};
	assign db    = {s_q[DW-1], s_q} - {k0[DW-1], k0};
	assign go_md = sel_ok && !hit_q && (span > 0);

	assign amag   = da[DW] ? $unsigned(-da) : $unsigned(da);
	assign bmag   = db[DW] ? $unsigned(-db) : $unsigned(db);
	assign span_u = $unsigned(span);

	assign addend  = mode_q ? '0 : SW'(s_q);
	assign sum_hit = SW'(hv_q) + addend;
	assign qs      = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	assign sum_int = SW'(v0_q) + SW'(qs) + addend;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_ch.command)
						CMD_CLEAR:  state_d = ST_FIN;
						CMD_INSERT: state_d = (count_q >= CW'(TABLE_DEPTH)) ? ST_FIN : ST_INS_RD;
						default:    state_d = ST_SCAN;
					endcase
				end
			end
			ST_INS_RD:  state_d = (pos_q == '0) ? ST_FIN : ST_INS_CMP;
			ST_INS_CMP: state_d = (rk > s_q) ? ST_INS_RD : ST_FIN;
			ST_SCAN:    if (idx_q == count_q && !val_s1) state_d = ST_CALC;
			ST_CALC:    state_d = go_md ? ST_MULDIV : ST_FIN;
			ST_MULDIV:  if (md_done) state_d = ST_SUM;
			ST_SUM:     state_d = ST_FIN;
			ST_FIN:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		re = 1'b0;
		we = 1'b0;
		ra = idx_q[AW-1:0];
		wa = pos_q[AW-1:0];
		wd = {s_q, v_q};
		md_start = 1'b0;
		case (state_q)
			ST_IDLE: in_ch.ready = 1'b1;
			ST_INS_RD: begin
				if (pos_q != '0) begin
					re = 1'b1;
					ra = AW'(pos_q - 1'b1);
				end else begin
					we = 1'b1;
				end
			end
			ST_INS_CMP: begin
				we = 1'b1;
				if (rk > s_q) wd = rdata_q;
			end
			ST_SCAN: re = idx_q < count_q;
			ST_CALC: md_start = go_md;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		if (re) rdata_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			tol_q       <= TOL_WIDTH'(1);
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
			val_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			val_s1  <= (state_q == ST_SCAN) && re;
			if (cfg_we) begin
				case (cfg_index)
					CFG_TOLERANCE: tol_q  <= cfg_data;
					CFG_MODE:      mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept && in_ch.command == CMD_CLEAR) count_q <= '0;
			if ((state_q == ST_INS_RD && pos_q == '0) ||
			    (state_q == ST_INS_CMP && !(rk > s_q))) count_q <= count_q + 1'b1;
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					s_q       <= in_ch.sample_or_key;
					v_q       <= in_ch.entry_value;
					pos_q     <= count_q;
					idx_q     <= '0;
					hit_q     <= 1'b0;
					have_lo_q <= 1'b0;
					have_hi_q <= 1'b0;
					res_q     <= '0;
					oc_q      <= (in_ch.command == CMD_INSERT && count_q >= CW'(TABLE_DEPTH))
					             ? OC_FULL : OC_STORED;
				end
			end
			ST_INS_CMP: if (rk > s_q) pos_q <= pos_q - 1'b1;
			ST_SCAN: begin
				if (re) idx_q <= idx_q + 1'b1;
				if (val_s1) begin
					if (in_tol && !hit_q) begin
						hit_q <= 1'b1;
						hv_q  <= rv;
					end
					if (rk < s_q) begin
						if (!have_lo_q) begin
							lk_q <= rk; lv_q <= rv; pk_q <= rk; pv_q <= rv;
							have_lo_q <= 1'b1;
						end else if (rk > lk_q) begin
							pk_q <= lk_q; pv_q <= lv_q; lk_q <= rk; lv_q <= rv;
						end
					end
					if (rk > s_q && (!have_hi_q || rk < uk_q)) begin
						uk_q <= rk; uv_q <= rv;
						have_hi_q <= 1'b1;
					end
					if (idx_s1 == AW'(0)) begin
						e0k_q <= rk; e0v_q <= rv;
					end
					if (idx_s1 == AW'(1)) begin
						e1k_q <= rk; e1v_q <= rv;
					end
				end
			end
			ST_CALC: begin
				if (hit_q) begin
					res_q <= sat(sum_hit);
					oc_q  <= OC_EXACT;
				end else if (!go_md) begin
					res_q <= s_q;
					oc_q  <= OC_PASS;
				end else begin
					oc_q  <= sel_oc;
					v0_q  <= v0;
					neg_q <= da[DW] ^ db[DW];
				end
			end
			ST_SUM: res_q <= sat(sum_int);
			ST_FIN: begin
				if (out_free) begin
					out_ch.result_value <= res_q;
					out_ch.outcome      <= oc_q;
					out_ch.entries_held <= count_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid = out_valid_q;

	cti_muldiv #(.DW(DW)) u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (md_start),
		.a_mag   (amag),
		.b_mag   (bmag),
		.divisor (span_u),
		.done    (md_done),
		.quot    (quot)
	);

endmodule
`default_nettype wire
